// ===== sv/cci_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cci_pkg
// Shared types, codes and helpers for the carousel column indexer.
// ============================================================================
package cci_pkg;

    localparam int NUM_COLUMNS_DEF = 6;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [2:0] REG_SPACING  = 3'd0;
    localparam logic [2:0] REG_IGNORE   = 3'd1;
    localparam logic [2:0] REG_TRIM     = 3'd2;
    localparam logic [2:0] REG_RUN_SPD  = 3'd3;
    localparam logic [2:0] REG_RUN_ACC  = 3'd4;
    localparam logic [2:0] REG_SRCH_SPD = 3'd5;

    // input actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // motor commands
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_MOVE_REL   = 3'd1;
    localparam logic [2:0] CMD_FORCE_STOP = 3'd2;
    localparam logic [2:0] CMD_RUN_CW     = 3'd3;
    localparam logic [2:0] CMD_SMOOTH     = 3'd4;
    localparam logic [2:0] CMD_STOP_RUN   = 3'd5;

    // status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_ALREADY = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_MOVE   = 4'b0010,
        PH_SEARCH = 4'b0100,
        PH_TRIM   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic               action;
        logic [2:0]         target_column;
        logic signed [31:0] motor_position;
        logic               sensor_level;
        logic               motor_running;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  command;
        logic [26:0] command_steps;
        logic [15:0] command_speed;
        logic [15:0] command_accel;
        logic [2:0]  status;
        logic [2:0]  column_now;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        logic [23:0] column_spacing;
        logic [23:0] ignore_distance;
        logic [23:0] trim_steps;
        logic [15:0] run_speed;
        logic [15:0] run_accel;
        logic [15:0] search_speed;
    } t_cfg;

    // core to result queue
    typedef struct packed {
        logic push;
        logic two;
    } t_push;

    function automatic t_out_word mk_word(input logic [2:0]  cmd,
                                          input logic [26:0] steps,
                                          input logic [15:0] speed,
                                          input logic [15:0] accel,
                                          input logic [2:0]  status);
        t_out_word w;
        w.command       = cmd;
        w.command_steps = steps;
        w.command_speed = speed;
        w.command_accel = accel;
        w.status        = status;
        w.column_now    = 3'd0;
        w.last_result   = 1'b0;
        return w;
    endfunction

endpackage

// ===== sv/carousel_column_indexer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// carousel_column_indexer
// Column positioning controller for a clockwise-only rotary store.
// ============================================================================
// The block takes one input word per clock cycle while the result queue has
// room. A word is held in an input register, stepped through the positioning
// logic once the queue has room for both of its possible results, and its one
// or two result words are written to a four-entry result queue, so the first
// result of a word is valid at the output once the word has passed the input
// register and been written to the queue. A word that causes two results (force
// stop followed by the finish command, or continuous run followed by the finish
// command) puts both into the queue; the queue admits a new word whenever it has
// two free entries, so with the output side always ready the sustained rate
// is one word per cycle for single-result words. Registers are written over
// the APB-style port at byte address 4*index and should only be changed
// while the block is idle. There is no clearing pass after reset.
// ============================================================================
module carousel_column_indexer
    import cci_pkg::*;
#(
    parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      cfg;
    t_in_word  r_in;
    logic      r_in_valid;
    logic      q_room;
    logic      go;
    t_push     push;
    t_out_word res0, res1;

    // step the held word once both results are sure to fit in the queue
    assign go         = r_in_valid && q_room;
    assign o_in_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in <= i_in_word;
    end

    cci_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cci_core #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    cci_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_w0    (res0),
        .i_w1    (res1),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// ===== sv/cci_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cci_regs
// APB-style configuration registers, zero wait state.
// ============================================================================
module cci_regs
    import cci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_SPACING:  r_cfg.column_spacing  <= pwdata[23:0];
                REG_IGNORE:   r_cfg.ignore_distance <= pwdata[23:0];
                REG_TRIM:     r_cfg.trim_steps      <= pwdata[23:0];
                REG_RUN_SPD:  r_cfg.run_speed       <= pwdata[15:0];
                REG_RUN_ACC:  r_cfg.run_accel       <= pwdata[15:0];
                REG_SRCH_SPD: r_cfg.search_speed    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SPACING:  prdata = {8'd0, r_cfg.column_spacing};
            REG_IGNORE:   prdata = {8'd0, r_cfg.ignore_distance};
            REG_TRIM:     prdata = {8'd0, r_cfg.trim_steps};
            REG_RUN_SPD:  prdata = {16'd0, r_cfg.run_speed};
            REG_RUN_ACC:  prdata = {16'd0, r_cfg.run_accel};
            REG_SRCH_SPD: prdata = {16'd0, r_cfg.search_speed};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/cci_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cci_core
// Positioning state and single-pass step logic; up to two results a word.
// ============================================================================
module cci_core
    import cci_pkg::*;
#(
    parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_push     o_push,
    output t_out_word o_res0,
    output t_out_word o_res1
);

    localparam logic [3:0] NCOL = 4'(NUM_COLUMNS);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cur, n_cur;
    logic [2:0]  r_tgt, n_tgt;
    logic [2:0]  r_need, n_need;
    logic [31:0] r_start, n_start;
    logic        r_prev, n_prev;
    logic        r_chk, n_chk;
    logic [2:0]  r_edges, n_edges;

    t_out_word   res0, res1, fin_word;
    t_phase      fin_phase;
    logic        fin_done;
    logic        two;
    logic [3:0]  dsum;
    logic [2:0]  col_dist;
    logic [31:0] pos, diff, moved;
    logic        ps, rise;
    logic [2:0]  edges_new;

    always_comb begin
        // clockwise distance, wrapping at NUM_COLUMNS
        dsum = {1'b0, i_word.target_column} + NCOL - {1'b0, r_cur};
        if (dsum >= NCOL) dsum = dsum - NCOL;
        col_dist = dsum[2:0];

        pos   = i_word.motor_position;
        diff  = pos - r_start;
        moved = diff[31] ? (~diff + 32'd1) : diff;

        ps        = r_chk ? r_prev : i_word.sensor_level;
        rise      = i_word.sensor_level && !ps && (r_edges != 3'd7);
        edges_new = r_edges + {2'd0, rise};

        if (i_cfg.trim_steps != 24'd0) begin
            fin_word  = mk_word(CMD_SMOOTH, {3'd0, i_cfg.trim_steps}, 16'd0, 16'd0, ST_BUSY);
            fin_phase = PH_TRIM;
            fin_done  = 1'b0;
        end else begin
            fin_word  = mk_word(CMD_STOP_RUN, 27'd0, 16'd0, 16'd0, ST_DONE);
            fin_phase = PH_IDLE;
            fin_done  = 1'b1;
        end

        n_phase = r_phase;
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_need  = r_need;
        n_start = r_start;
        n_prev  = r_prev;
        n_chk   = r_chk;
        n_edges = r_edges;
        res0    = mk_word(CMD_NONE, 27'd0, 16'd0, 16'd0, ST_BUSY);
        res1    = res0;
        two     = 1'b0;

        if (i_word.action == ACT_START) begin
            if (r_phase != PH_IDLE) begin
                res0.status = ST_IGNORED;
            end else if ({1'b0, i_word.target_column} >= NCOL) begin
                res0.status = ST_INVALID;
            end else if (i_word.target_column == r_cur) begin
                res0.status = ST_ALREADY;
            end else begin
                n_tgt   = i_word.target_column;
                n_need  = col_dist;
                n_start = pos;
                n_prev  = 1'b0;
                n_chk   = 1'b0;
                n_edges = 3'd0;
                n_phase = PH_MOVE;
                res0    = mk_word(CMD_MOVE_REL, 27'(col_dist) * 27'(i_cfg.column_spacing),
                                  i_cfg.run_speed, i_cfg.run_accel, ST_BUSY);
            end
        end else begin
            case (r_phase)
                PH_MOVE: begin
                    if (!i_word.motor_running) begin
                        res0    = mk_word(CMD_RUN_CW, 27'd0, i_cfg.search_speed, 16'd0,
                                          ST_BUSY);
                        n_phase = PH_SEARCH;
                        if (i_word.sensor_level) begin
                            res1    = fin_word;
                            two     = 1'b1;
                            n_phase = fin_phase;
                            if (fin_done) n_cur = r_tgt;
                        end
                    end else if (moved > {8'd0, i_cfg.ignore_distance}) begin
                        n_chk   = 1'b1;
                        n_prev  = i_word.sensor_level;
                        n_edges = edges_new;
                        if (edges_new >= r_need) begin
                            res0.command = CMD_FORCE_STOP;
                            res1         = fin_word;
                            two          = 1'b1;
                            n_phase      = fin_phase;
                            if (fin_done) n_cur = r_tgt;
                        end
                    end
                end
                PH_SEARCH: begin
                    if (i_word.sensor_level) begin
                        res0    = fin_word;
                        n_phase = fin_phase;
                        if (fin_done) n_cur = r_tgt;
                    end
                end
                PH_TRIM: begin
                    if (!i_word.motor_running) begin
                        n_cur       = r_tgt;
                        n_phase     = PH_IDLE;
                        res0.status = ST_DONE;
                    end
                end
                default: begin
                    res0.status = ST_IDLE;
                end
            endcase
        end

        res0.column_now  = n_cur;
        res1.column_now  = n_cur;
        res0.last_result = !two;
        res1.last_result = 1'b1;
    end

    assign o_res0      = res0;
    assign o_res1      = res1;
    assign o_push.push = i_go;
    assign o_push.two  = two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cur   <= 3'd0;
            r_tgt   <= 3'd0;
            r_need  <= 3'd0;
            r_start <= 32'd0;
            r_prev  <= 1'b0;
            r_chk   <= 1'b0;
            r_edges <= 3'd0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_need  <= n_need;
            r_start <= n_start;
            r_prev  <= n_prev;
            r_chk   <= n_chk;
            r_edges <= n_edges;
        end
    end

endmodule

// ===== sv/cci_out_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cci_out_queue
// Small result queue: takes one or two words a cycle, hands out one.
// ============================================================================
module cci_out_queue
    import cci_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  t_out_word i_w0,
    input  t_out_word i_w1,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    t_out_word          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;
    logic [QCNT_W-1:0]  n_in;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign n_in    = !i_push.push ? QCNT_W'(0) : (i_push.two ? QCNT_W'(2) : QCNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_w0;
            if (i_push.two) r_mem[r_wr + QPTR_W'(1)] <= i_w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(n_in);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + n_in - QCNT_W'(pop);
        end
    end

endmodule

// ===== sv/cci_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cci_checker
// Port-level checks for the carousel column indexer.
// ============================================================================
module cci_checker
    import cci_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_word   o_out_word
);

    // a pending result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // done only comes with no command or the stop of a continuous run
    a_done_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_DONE |->
            o_out_word.command == CMD_NONE || o_out_word.command == CMD_STOP_RUN)
        else $error("done status with unexpected command");

    // a column move is the only result of its start word
    a_move_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.command == CMD_MOVE_REL |->
            o_out_word.status == ST_BUSY && o_out_word.last_result)
        else $error("column move not a single busy result");

    // a force stop is always followed by the finish word
    a_stop_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.command == CMD_FORCE_STOP |-> !o_out_word.last_result)
        else $error("force stop marked as final result");

endmodule

bind carousel_column_indexer cci_checker u_cci_checker (.*);
